[rtl/assert_macros.svh]
// assertion macros shared by the rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/mi3_pkg.sv]
// types, widths and divider step functions for the 3x3 inverse
// no dependencies
`default_nettype none
package mi3_pkg;
    localparam int IN_FRAC_BITS  = 12;
    localparam int OUT_FRAC_BITS = 16;
    localparam int FRAC_SHIFT    = IN_FRAC_BITS + OUT_FRAC_BITS;
    localparam int IN_W          = 16;
    localparam int OUT_W         = 32;
    localparam int PROD_W        = 2 * IN_W;
    localparam int COF_W         = PROD_W + 1;
    localparam int MAG_W         = COF_W - 1;
    localparam int DET_W         = IN_W + COF_W;
    localparam int DEN_W         = DET_W - 1;
    localparam int REM_W         = DEN_W + 1;
    localparam int NLO_W         = OUT_W - FRAC_SHIFT;
    localparam int N_ENT         = 9;
    localparam int DIV_STEPS     = OUT_W;
    localparam int FQ_DEPTH      = 4;
    localparam int FQ_AW         = $clog2(FQ_DEPTH);

    typedef struct packed {
        logic signed [IN_W-1:0] m00;
        logic signed [IN_W-1:0] m01;
        logic signed [IN_W-1:0] m02;
        logic signed [IN_W-1:0] m10;
        logic signed [IN_W-1:0] m11;
        logic signed [IN_W-1:0] m12;
        logic signed [IN_W-1:0] m20;
        logic signed [IN_W-1:0] m21;
        logic signed [IN_W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] inv00;
        logic signed [OUT_W-1:0] inv01;
        logic signed [OUT_W-1:0] inv02;
        logic signed [OUT_W-1:0] inv10;
        logic signed [OUT_W-1:0] inv11;
        logic signed [OUT_W-1:0] inv12;
        logic signed [OUT_W-1:0] inv20;
        logic signed [OUT_W-1:0] inv21;
        logic signed [OUT_W-1:0] inv22;
        logic                    singular;
        logic                    saturated;
    } t_out;

    typedef struct packed {
        logic [N_ENT-1:0][MAG_W-1:0] mag;
        logic [N_ENT-1:0]            neg;
        logic [DEN_W-1:0]            den;
        logic                        sing;
    } t_fq;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [OUT_W-1:0] quo;
        logic [NLO_W-1:0] nlo;
        logic             neg;
        logic             big;
    } t_lane;

    typedef struct packed {
        t_lane [N_ENT-1:0] lane;
        logic [DEN_W-1:0]  den;
        logic              sing;
    } t_bstage;

    function automatic t_lane div_load(logic [MAG_W-1:0] mag, logic neg,
                                       logic [DEN_W-1:0] den);
        t_lane l;
        l.rem = REM_W'(mag[MAG_W-1:NLO_W]);
        l.big = (l.rem >= REM_W'(den));
        l.quo = '0;
        l.nlo = mag[NLO_W-1:0];
        l.neg = neg;
        return l;
    endfunction

    function automatic t_lane div_step(t_lane li, logic [DEN_W-1:0] den);
        t_lane            l;
        logic [REM_W-1:0] t;
        l = li;
        t = {li.rem[REM_W-2:0], li.nlo[NLO_W-1]};
        if (t >= REM_W'(den)) begin
            l.rem = t - REM_W'(den);
            l.quo = {li.quo[OUT_W-2:0], 1'b1};
        end else begin
            l.rem = t;
            l.quo = {li.quo[OUT_W-2:0], 1'b0};
        end
        l.nlo = {li.nlo[NLO_W-2:0], 1'b0};
        return l;
    endfunction
endpackage
`default_nettype wire

[rtl/mi3_front.sv]
// front end: cofactors, determinant and sign/magnitude split, four stages
// depends on mi3_pkg
`default_nettype none
module mi3_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_stall,
    input  mi3_pkg::t_in    i_data,
    input  wire             i_full,
    output logic            o_push,
    output mi3_pkg::t_fq    o_entry
);
    logic signed [mi3_pkg::PROD_W-1:0] r_pa   [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::PROD_W-1:0] r_pb   [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof2 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::COF_W-1:0]  r_cof3 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::IN_W-1:0]   r_row1 [3];
    logic signed [mi3_pkg::IN_W-1:0]   r_row2 [3];
    logic signed [mi3_pkg::DET_W-1:0]  r_dp3  [3];
    mi3_pkg::t_fq                      r_q, n_q;
    logic                              r_v1, r_v2, r_v3, r_v4;
    logic                              en;
    logic signed [mi3_pkg::DET_W-1:0]  det;
    logic signed [mi3_pkg::COF_W-1:0]  cmag;
    logic signed [mi3_pkg::DET_W-1:0]  dmag;

    assign en      = !r_v4 || !i_full;
    assign o_stall = !en;
    assign o_push  = r_v4 && !i_full;
    assign o_entry = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // products of the 2x2 minors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pa[0] <= mi3_pkg::PROD_W'(i_data.m11 * i_data.m22);
            r_pb[0] <= mi3_pkg::PROD_W'(i_data.m12 * i_data.m21);
            r_pa[1] <= mi3_pkg::PROD_W'(i_data.m02 * i_data.m21);
            r_pb[1] <= mi3_pkg::PROD_W'(i_data.m01 * i_data.m22);
            r_pa[2] <= mi3_pkg::PROD_W'(i_data.m01 * i_data.m12);
            r_pb[2] <= mi3_pkg::PROD_W'(i_data.m02 * i_data.m11);
            r_pa[3] <= mi3_pkg::PROD_W'(i_data.m12 * i_data.m20);
            r_pb[3] <= mi3_pkg::PROD_W'(i_data.m10 * i_data.m22);
            r_pa[4] <= mi3_pkg::PROD_W'(i_data.m00 * i_data.m22);
            r_pb[4] <= mi3_pkg::PROD_W'(i_data.m02 * i_data.m20);
            r_pa[5] <= mi3_pkg::PROD_W'(i_data.m02 * i_data.m10);
            r_pb[5] <= mi3_pkg::PROD_W'(i_data.m00 * i_data.m12);
            r_pa[6] <= mi3_pkg::PROD_W'(i_data.m10 * i_data.m21);
            r_pb[6] <= mi3_pkg::PROD_W'(i_data.m11 * i_data.m20);
            r_pa[7] <= mi3_pkg::PROD_W'(i_data.m01 * i_data.m20);
            r_pb[7] <= mi3_pkg::PROD_W'(i_data.m00 * i_data.m21);
            r_pa[8] <= mi3_pkg::PROD_W'(i_data.m00 * i_data.m11);
            r_pb[8] <= mi3_pkg::PROD_W'(i_data.m01 * i_data.m10);
            r_row1[0] <= i_data.m00;
            r_row1[1] <= i_data.m01;
            r_row1[2] <= i_data.m02;
            for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
                r_cof2[k] <= mi3_pkg::COF_W'(r_pa[k]) - mi3_pkg::COF_W'(r_pb[k]);
                r_cof3[k] <= r_cof2[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_row2[k] <= r_row1[k];
            end
            r_dp3[0] <= mi3_pkg::DET_W'(r_row2[0]) * mi3_pkg::DET_W'(r_cof2[0]);
            r_dp3[1] <= mi3_pkg::DET_W'(r_row2[1]) * mi3_pkg::DET_W'(r_cof2[3]);
            r_dp3[2] <= mi3_pkg::DET_W'(r_row2[2]) * mi3_pkg::DET_W'(r_cof2[6]);
            r_q <= n_q;
        end
    end

    always_comb begin
        det  = r_dp3[0] + r_dp3[1] + r_dp3[2];
        dmag = det[mi3_pkg::DET_W-1] ? -det : det;
        n_q.den  = dmag[mi3_pkg::DEN_W-1:0];
        n_q.sing = (det == '0);
        cmag = '0;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            cmag = r_cof3[k][mi3_pkg::COF_W-1] ? -r_cof3[k] : r_cof3[k];
            n_q.mag[k] = cmag[mi3_pkg::MAG_W-1:0];
            n_q.neg[k] = r_cof3[k][mi3_pkg::COF_W-1] ^ det[mi3_pkg::DET_W-1];
        end
    end
endmodule
`default_nettype wire

[rtl/mi3_queue.sv]
// short queue between front and back ends
// depends on mi3_pkg
`default_nettype none
module mi3_queue (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_push,
    input  mi3_pkg::t_fq i_entry,
    output logic         o_full,
    input  wire          i_pop,
    output logic         o_empty,
    output mi3_pkg::t_fq o_entry
);
    mi3_pkg::t_fq                r_mem [mi3_pkg::FQ_DEPTH];
    logic [mi3_pkg::FQ_AW-1:0]   r_wp, r_rp;
    logic [mi3_pkg::FQ_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (mi3_pkg::FQ_AW + 1)'(mi3_pkg::FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/mi3_back.sv]
// back end: nine pipelined restoring dividers, one quotient bit a stage,
// then saturation into the output register; depends on mi3_pkg
`default_nettype none
module mi3_back (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_empty,
    input  mi3_pkg::t_fq  i_entry,
    output logic          o_pop,
    output logic          o_valid,
    input  wire           i_stall,
    output mi3_pkg::t_out o_data
);
    mi3_pkg::t_bstage r_st [mi3_pkg::DIV_STEPS+1];
    logic             r_sv [mi3_pkg::DIV_STEPS+1];
    logic             r_ov;
    mi3_pkg::t_out    r_out, n_out;
    logic             en;
    logic [mi3_pkg::N_ENT-1:0]                ovf;
    logic [mi3_pkg::N_ENT-1:0][mi3_pkg::OUT_W-1:0] val;
    mi3_pkg::t_lane   fl;

    assign en      = !r_ov || !i_stall;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
                r_st[0].lane[k] <= mi3_pkg::div_load(i_entry.mag[k], i_entry.neg[k],
                                                     i_entry.den);
            end
            r_st[0].den  <= i_entry.den;
            r_st[0].sing <= i_entry.sing;
        end
    end

    for (genvar s = 0; s < mi3_pkg::DIV_STEPS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else if (en) begin
                r_sv[s+1] <= r_sv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
                    r_st[s+1].lane[k] <= mi3_pkg::div_step(r_st[s].lane[k], r_st[s].den);
                end
                r_st[s+1].den  <= r_st[s].den;
                r_st[s+1].sing <= r_st[s].sing;
            end
        end
    end

    always_comb begin
        fl = '0;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            fl = r_st[mi3_pkg::DIV_STEPS].lane[k];
            ovf[k] = fl.big || (fl.neg ? (fl.quo[mi3_pkg::OUT_W-1] &&
                                          (|fl.quo[mi3_pkg::OUT_W-2:0]))
                                       : fl.quo[mi3_pkg::OUT_W-1]);
            if (r_st[mi3_pkg::DIV_STEPS].sing) begin
                val[k] = '0;
            end else if (ovf[k]) begin
                val[k] = fl.neg ? {1'b1, {(mi3_pkg::OUT_W-1){1'b0}}}
                                : {1'b0, {(mi3_pkg::OUT_W-1){1'b1}}};
            end else begin
                val[k] = fl.neg ? -fl.quo : fl.quo;
            end
        end
        n_out.inv00     = val[0];
        n_out.inv01     = val[1];
        n_out.inv02     = val[2];
        n_out.inv10     = val[3];
        n_out.inv11     = val[4];
        n_out.inv12     = val[5];
        n_out.inv20     = val[6];
        n_out.inv21     = val[7];
        n_out.inv22     = val[8];
        n_out.singular  = r_st[mi3_pkg::DIV_STEPS].sing;
        n_out.saturated = !r_st[mi3_pkg::DIV_STEPS].sing && (|ovf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv[mi3_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire

[rtl/matrix3_inverse.sv]
// 3x3 matrix inverse in fixed point, top level
// depends on mi3_pkg, mi3_front, mi3_queue, mi3_back, assert_macros.svh
//
// input channel: one Q4.12 3x3 matrix a beat on i_data, taken when i_valid is
// high and o_stall is low. output channel: the Q16.16 inverse with singular
// and saturated flags on o_data, taken when o_valid is high and i_stall low.
// one matrix is accepted every cycle while o_stall is low; a result passes
// through four front stages (minor products, cofactors, determinant terms,
// determinant and sign split), the four-entry queue, one divider load stage,
// 32 divider stages (one quotient bit each, nine dividers in parallel) and
// the output register.
// a stall on the output freezes the divider pipeline only; the front keeps
// taking beats until the queue fills, then raises o_stall.
// reset clears all valid bits and the queue pointers; nothing else is held.
`default_nettype none
`include "assert_macros.svh"
module matrix3_inverse (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_stall,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    input  wire           i_stall,
    output mi3_pkg::t_out o_data
);
    logic         q_push, q_full, q_pop, q_empty;
    mi3_pkg::t_fq q_in, q_out;
    logic         inv_zero;

    assign inv_zero = (o_data[$bits(mi3_pkg::t_out)-1:2] == '0);

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    mi3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    mi3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_entry (q_out),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    `ASSERT_IMPLIES(a_sing_zero, i_clk, i_rst_n, o_valid && o_data.singular, inv_zero)
    `ASSERT_ALWAYS(a_sing_nosat, i_clk, i_rst_n, !(o_valid && o_data.singular && o_data.saturated))
    `ASSERT_ALWAYS(a_no_pop_empty, i_clk, i_rst_n, !(q_pop && q_empty) && !(q_push && q_full))
endmodule
`default_nettype wire

[tb/tb_top.sv]
// testbench for matrix3_inverse: drives matrices, predicts the fixed point inverse
// depends on mi3_pkg and the matrix3_inverse rtl
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          i_stall = 1'b0;
    mi3_pkg::t_in  i_data = '0;
    logic          o_stall;
    logic          o_valid;
    mi3_pkg::t_out o_data;

    mi3_pkg::t_in  pending_mats[$];
    mi3_pkg::t_out expected_invs[$];
    int   errors = 0;
    int   n_sent = 0;
    int   n_got = 0;
    int   n_sing = 0;
    int   n_sat = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   idle_cycles = 0;
    bit   hold_sender = 1'b0;

    matrix3_inverse dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] quotient_q16(longint num, longint den, ref bit sat);
        longint unsigned n, d, q, r, lim;
        bit neg, over;
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        neg = (num < 0) != (den < 0);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        over = 1'b0;
        if (n == 0 || d == 0) return '0;
        q = n / d;
        r = n % d;
        if (q > lim) over = 1'b1;
        for (int i = 0; i < mi3_pkg::IN_FRAC_BITS + mi3_pkg::OUT_FRAC_BITS && !over; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
            if (q > lim) over = 1'b1;
        end
        if (over) begin
            sat = 1'b1;
            q = lim;
        end
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function automatic mi3_pkg::t_out invert_matrix(mi3_pkg::t_in m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, det;
        longint cof[9];
        logic [31:0] e[9];
        bit sat;
        mi3_pkg::t_out o;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        cof[0] = a11 * a22 - a12 * a21;
        cof[1] = a02 * a21 - a01 * a22;
        cof[2] = a01 * a12 - a02 * a11;
        cof[3] = a12 * a20 - a10 * a22;
        cof[4] = a00 * a22 - a02 * a20;
        cof[5] = a02 * a10 - a00 * a12;
        cof[6] = a10 * a21 - a11 * a20;
        cof[7] = a01 * a20 - a00 * a21;
        cof[8] = a00 * a11 - a01 * a10;
        det = a00 * cof[0] + a01 * cof[3] + a02 * cof[6];
        o = '0;
        sat = 1'b0;
        if (det == 0) begin
            o.singular = 1'b1;
            return o;
        end
        for (int i = 0; i < 9; i++) e[i] = quotient_q16(cof[i], det, sat);
        o.inv00 = e[0]; o.inv01 = e[1]; o.inv02 = e[2];
        o.inv10 = e[3]; o.inv11 = e[4]; o.inv12 = e[5];
        o.inv20 = e[6]; o.inv21 = e[7]; o.inv22 = e[8];
        o.saturated = sat;
        return o;
    endfunction

    function automatic mi3_pkg::t_in make_mat(int v00, int v01, int v02, int v10, int v11,
                                              int v12, int v20, int v21, int v22);
        mi3_pkg::t_in m;
        m.m00 = 16'(v00); m.m01 = 16'(v01); m.m02 = 16'(v02);
        m.m10 = 16'(v10); m.m11 = 16'(v11); m.m12 = 16'(v12);
        m.m20 = 16'(v20); m.m21 = 16'(v21); m.m22 = 16'(v22);
        return m;
    endfunction

    function automatic logic [15:0] rand_entry(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 8192)) - 4096);
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic mi3_pkg::t_in random_mat();
        mi3_pkg::t_in m;
        int mode;
        int kind;
        mode = $urandom_range(0, 9);
        mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
        m.m00 = rand_entry(mode); m.m01 = rand_entry(mode); m.m02 = rand_entry(mode);
        m.m10 = rand_entry(mode); m.m11 = rand_entry(mode); m.m12 = rand_entry(mode);
        m.m20 = rand_entry(mode); m.m21 = rand_entry(mode); m.m22 = rand_entry(mode);
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            m.m10 = m.m00; m.m11 = m.m01; m.m12 = m.m02;
        end else if (kind == 1) begin
            m.m02 = '0; m.m12 = '0; m.m22 = '0;
        end else if (kind == 2) begin
            m.m01 = '0; m.m02 = '0; m.m10 = '0; m.m12 = '0; m.m20 = '0; m.m21 = '0;
        end
        return m;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            in_gap <= 0;
        end else if (i_valid && o_stall) begin
        end else begin
            if (i_valid) begin
                expected_invs.push_back(invert_matrix(i_data));
                n_sent++;
            end
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_mats.size() > 0 && !hold_sender) begin
                i_data <= pending_mats.pop_front();
                i_valid <= 1'b1;
                in_gap <= rand_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and output stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            out_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                mi3_pkg::t_out x;
                if (expected_invs.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    x = expected_invs.pop_front();
                    n_got++;
                    if (x.singular) n_sing++;
                    if (x.saturated) n_sat++;
                    if (o_data.inv00 !== x.inv00) begin
                        $error("inv00 exp %h got %h", x.inv00, o_data.inv00); errors++;
                    end
                    if (o_data.inv01 !== x.inv01) begin
                        $error("inv01 exp %h got %h", x.inv01, o_data.inv01); errors++;
                    end
                    if (o_data.inv02 !== x.inv02) begin
                        $error("inv02 exp %h got %h", x.inv02, o_data.inv02); errors++;
                    end
                    if (o_data.inv10 !== x.inv10) begin
                        $error("inv10 exp %h got %h", x.inv10, o_data.inv10); errors++;
                    end
                    if (o_data.inv11 !== x.inv11) begin
                        $error("inv11 exp %h got %h", x.inv11, o_data.inv11); errors++;
                    end
                    if (o_data.inv12 !== x.inv12) begin
                        $error("inv12 exp %h got %h", x.inv12, o_data.inv12); errors++;
                    end
                    if (o_data.inv20 !== x.inv20) begin
                        $error("inv20 exp %h got %h", x.inv20, o_data.inv20); errors++;
                    end
                    if (o_data.inv21 !== x.inv21) begin
                        $error("inv21 exp %h got %h", x.inv21, o_data.inv21); errors++;
                    end
                    if (o_data.inv22 !== x.inv22) begin
                        $error("inv22 exp %h got %h", x.inv22, o_data.inv22); errors++;
                    end
                    if (o_data.singular !== x.singular) begin
                        $error("singular exp %b got %b", x.singular, o_data.singular);
                        errors++;
                    end
                    if (o_data.saturated !== x.saturated) begin
                        $error("saturated exp %b got %b", x.saturated, o_data.saturated);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                out_gap <= rand_gap();
            end
        end
    end

    // watchdog on beats in either direction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("matrix3_inverse: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed
        pending_mats.push_back(make_mat(4096, 0, 0, 0, 4096, 0, 0, 0, 4096));
        pending_mats.push_back(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_mats.push_back(make_mat(-1, 0, 0, 0, 1, 0, 0, 0, -1));
        pending_mats.push_back(make_mat(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
        pending_mats.push_back(make_mat(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
        pending_mats.push_back(make_mat(32767, 32767, 32767, 32767, 32767, 32767,
                                        32767, 32767, 32767));
        pending_mats.push_back(make_mat(-32768, 32767, -32768, 32767, -32768, 32767,
                                        -32768, 32767, -32767));
        pending_mats.push_back(make_mat(-32768, -32768, -32768, -32768, 32767, 0,
                                        -32768, 0, 32767));
        pending_mats.push_back(make_mat(1, 2, 3, 4, 5, 6, 7, 8, 10));
        pending_mats.push_back(make_mat(0, 4096, 0, 4096, 0, 0, 0, 0, 4096));
        pending_mats.push_back(make_mat(8192, 0, 0, 0, -4096, 0, 0, 0, 2048));
        pending_mats.push_back(make_mat(1, 1, 0, 1, 2, 0, 0, 0, 1));
        pending_mats.push_back(make_mat(32767, 1, 0, -1, 32767, 0, 0, 0, 1));
        pending_mats.push_back(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        pending_mats.push_back(make_mat(3, -7, 11, -13, 17, -19, 23, -29, 31));
        wait (pending_mats.size() == 0 && !i_valid);
        // pause the sender until everything is back
        hold_sender = 1'b1;
        wait (expected_invs.size() == 0);
        hold_sender = 1'b0;
        for (int i = 0; i < 500; i++) pending_mats.push_back(random_mat());
        wait (pending_mats.size() == 0 && !i_valid);
        wait (expected_invs.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("sent %0d matrices, checked %0d, %0d singular, %0d saturated",
                 n_sent, n_got, n_sing, n_sat);
        if (errors == 0 && expected_invs.size() == 0)
            $display("matrix3_inverse: match");
        else
            $display("matrix3_inverse: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_queue.sv
rtl/mi3_back.sv
rtl/matrix3_inverse.sv
tb/tb_top.sv
